/* src/prpol_pkg.sv */
// package for the per-type message rate policer
// types, widths, item codes and reset values shared by the controller, datapath and top level
`timescale 1ns / 1ps
`default_nettype none

package prpol_pkg;

  localparam int unsigned NUM_TYPES = 256;
  localparam int unsigned IDX_W     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int unsigned TYPE_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CNT_W     = 16;

  localparam logic [TIME_W-1:0] REFRESH_RST = TIME_W'(2000);
  localparam logic [CNT_W-1:0]  ALLOWED_RST = CNT_W'(1);
  localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_CHECK  = 2'd1,
    KIND_RECORD = 2'd2
  } kind_e;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] refresh;
    logic [CNT_W-1:0]  allowed;
  } rule_t;

  typedef struct packed {
    logic [TIME_W-1:0] last_acc;
    logic [TIME_W-1:0] last_ref;
    logic [CNT_W-1:0]  cnt;
  } hist_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic capture;
    logic read;
    logic calc;
    logic write;
  } cmd_t;

endpackage

`default_nettype wire

/* src/per_type_message_rate_policer.sv */
// top level of the per-type message rate policer
// depends on prpol_pkg, prpol_ctrl and prpol_dp
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------------------------
//   in      | input     | in_valid_i / in_stall_o  | kind, message_type, arrival_time, rule_*
//   out     | output    | out_valid_o / out_stall_i| accepted, known_type
//
// an item passes through accept, table read, compare, and table write-back with result load;
// the sequencer in prpol_ctrl handles one item at a time, so no new item is taken until write-back
// a stalled output holds the item in the write-back cycle until the result register frees up
// reset clears the rule-valid and history-open flags at once; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module per_type_message_rate_policer
  import prpol_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [1:0]        kind_i,
  input  wire  [TYPE_W-1:0] message_type_i,
  input  wire  [TIME_W-1:0] arrival_time_i,
  input  wire  [TIME_W-1:0] rule_min_gap_i,
  input  wire  [TIME_W-1:0] rule_refresh_period_i,
  input  wire  [CNT_W-1:0]  rule_allowed_errors_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic              accepted_o,
  output logic              known_type_o
);

  cmd_t cmd;

  prpol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  prpol_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .kind_i                (kind_i),
    .message_type_i        (message_type_i),
    .arrival_time_i        (arrival_time_i),
    .rule_min_gap_i        (rule_min_gap_i),
    .rule_refresh_period_i (rule_refresh_period_i),
    .rule_allowed_errors_i (rule_allowed_errors_i),
    .accepted_o            (accepted_o),
    .known_type_o          (known_type_o)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("policer took a new item while one is in flight");

  a_cmd_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("policer issued overlapping sequencer commands");

  a_write_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write |-> (!out_valid_o || !out_stall_i))
    else $error("policer overwrote a result still waiting downstream");

  a_write_to_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write |=> out_valid_o)
    else $error("policer wrote back an item without presenting its result");
`endif

endmodule

`default_nettype wire

/* src/prpol_ctrl.sv */
// controller for the rate policer: one-hot sequencer and output valid flag
// depends on prpol_pkg for the command struct
`timescale 1ns / 1ps
`default_nettype none

module prpol_ctrl
  import prpol_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_CALC  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   slot_free;

  assign slot_free = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_WRITE;
      end
      ST_WRITE: begin
        // table update and result load happen together, once the result slot is free
        if (slot_free) begin
          cmd_o.write = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.write) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

/* src/prpol_dp.sv */
// datapath for the rate policer: rule and history memories, compare logic, result register
// depends on prpol_pkg; sequenced by prpol_ctrl through cmd_t
`timescale 1ns / 1ps
`default_nettype none

module prpol_dp
  import prpol_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cmd_t              cmd_i,
  input  wire  [1:0]        kind_i,
  input  wire  [TYPE_W-1:0] message_type_i,
  input  wire  [TIME_W-1:0] arrival_time_i,
  input  wire  [TIME_W-1:0] rule_min_gap_i,
  input  wire  [TIME_W-1:0] rule_refresh_period_i,
  input  wire  [CNT_W-1:0]  rule_allowed_errors_i,
  output logic              accepted_o,
  output logic              known_type_o
);

  rule_t rule_mem [NUM_TYPES];
  hist_t hist_mem [NUM_TYPES];

  logic [NUM_TYPES-1:0] rule_vld_q;
  logic [NUM_TYPES-1:0] open_q;

  // captured item
  logic [1:0]        kind_q;
  logic [TYPE_W-1:0] type_q;
  logic [TIME_W-1:0] now_q;
  rule_t             rule_in_q;

  // read stage
  rule_t rule_rd_q;
  hist_t hist_rd_q;
  logic  rule_vld_rd_q;
  logic  open_rd_q;
  logic  known_q;

  // calc stage
  logic  accept_q;
  logic  hist_we_q;
  logic  rule_we_q;
  hist_t hist_new_q;

  logic              known;
  idx_t              idx;
  rule_t             rule_eff;
  logic [TIME_W-1:0] since_acc;
  logic [TIME_W-1:0] since_ref;
  logic              early;
  logic              late;
  logic              refresh_due;
  logic              accept_d;
  hist_t             hist_new_d;

  assign known = (type_q < TYPE_W'(NUM_TYPES));
  assign idx   = type_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q            <= kind_i;
      type_q            <= message_type_i;
      now_q             <= arrival_time_i;
      rule_in_q.gap     <= rule_min_gap_i;
      rule_in_q.refresh <= rule_refresh_period_i;
      rule_in_q.allowed <= rule_allowed_errors_i;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rule_rd_q     <= rule_mem[idx];
      hist_rd_q     <= hist_mem[idx];
      rule_vld_rd_q <= rule_vld_q[idx];
      open_rd_q     <= open_q[idx];
      known_q       <= known;
    end
  end

  // a rule never loaded reads as the reset rule
  always_comb begin
    if (rule_vld_rd_q) begin
      rule_eff = rule_rd_q;
    end else begin
      rule_eff.gap     = '0;
      rule_eff.refresh = REFRESH_RST;
      rule_eff.allowed = ALLOWED_RST;
    end
  end

  assign since_acc   = now_q - hist_rd_q.last_acc;
  assign since_ref   = now_q - hist_rd_q.last_ref;
  assign early       = (since_acc < rule_eff.gap);
  assign late        = (since_acc > rule_eff.gap);
  assign refresh_due = (since_ref > rule_eff.refresh);

  always_comb begin
    accept_d = 1'b1;
    if (!known_q) begin
      accept_d = (kind_q != KIND_CHECK);
    end else if (kind_q == KIND_CHECK && rule_eff.gap != '0 && open_rd_q && early
                 && hist_rd_q.cnt > rule_eff.allowed) begin
      accept_d = 1'b0;
    end
  end

  always_comb begin
    hist_new_d = hist_rd_q;
    if (!open_rd_q) begin
      hist_new_d.last_acc = now_q;
      hist_new_d.last_ref = now_q;
      hist_new_d.cnt      = '0;
    end else if (refresh_due) begin
      hist_new_d.last_acc = now_q;
      hist_new_d.last_ref = now_q;
      hist_new_d.cnt      = '0;
    end else if (late) begin
      hist_new_d.last_acc = now_q;
    end else if (hist_rd_q.cnt != CNT_MAX) begin
      hist_new_d.cnt = hist_rd_q.cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      accept_q   <= accept_d;
      hist_new_q <= hist_new_d;
      hist_we_q  <= known_q && (kind_q == KIND_RECORD) && (rule_eff.gap != '0);
      rule_we_q  <= known_q && (kind_q == KIND_LOAD);
    end
  end

  // memory write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      if (rule_we_q) begin
        rule_mem[idx] <= rule_in_q;
      end
      if (hist_we_q) begin
        hist_mem[idx] <= hist_new_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_vld_q <= '0;
      open_q     <= '0;
    end else if (cmd_i.write) begin
      if (rule_we_q) begin
        rule_vld_q[idx] <= 1'b1;
      end
      if (hist_we_q) begin
        open_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      accepted_o   <= accept_q;
      known_type_o <= known_q;
    end
  end

endmodule

`default_nettype wire

/* verif/tb_per_type_message_rate_policer.sv */
// self-checking testbench for the per-type message rate policer
// depends on prpol_pkg and per_type_message_rate_policer; keeps its own copy of the rule and
// history tables and matches each verdict against it
`timescale 1ns / 1ps

module tb_per_type_message_rate_policer;
  import prpol_pkg::*;

  localparam logic [1:0]  KIND_SPARE       = 2'd3;
  localparam int unsigned QUIET_LIMIT      = 5000;
  localparam int unsigned DRAIN_CYCLES     = 20;
  localparam int unsigned ITEMS_PER_PHASE  = 225;
  localparam int unsigned BURST_LEN        = 20;
  localparam logic [TYPE_W-1:0] BURST_TYPE = TYPE_W'(7);

  typedef struct packed {
    logic accepted;
    logic known;
  } verdict_t;

  // mirror of the policer tables plus the verdicts still owed by the block
  class policy_tracker;
    rule_t       rules[NUM_TYPES];
    hist_t       hist[NUM_TYPES];
    bit          hist_live[NUM_TYPES];
    verdict_t    verdict_q[$];
    int unsigned errors;

    function new();
      for (int i = 0; i < NUM_TYPES; i++) begin
        rules[i]     = '{gap: '0, refresh: REFRESH_RST, allowed: ALLOWED_RST};
        hist[i]      = '0;
        hist_live[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function void take_message(logic [1:0] kind, logic [TYPE_W-1:0] mtype,
                               logic [TIME_W-1:0] now, logic [TIME_W-1:0] gap_in,
                               logic [TIME_W-1:0] refresh_in, logic [CNT_W-1:0] allowed_in);
      verdict_t          v;
      idx_t              ix;
      rule_t             r;
      logic [TIME_W-1:0] since_acc;
      logic [TIME_W-1:0] since_ref;
      v.known    = (mtype < NUM_TYPES);
      v.accepted = 1'b1;
      ix         = mtype[IDX_W-1:0];
      if (v.known) begin
        r         = rules[ix];
        since_acc = now - hist[ix].last_acc;
        since_ref = now - hist[ix].last_ref;
        case (kind)
          KIND_LOAD: begin
            rules[ix] = '{gap: gap_in, refresh: refresh_in, allowed: allowed_in};
          end
          KIND_CHECK: begin
            if (r.gap != '0 && hist_live[ix] && since_acc < r.gap && hist[ix].cnt > r.allowed)
              v.accepted = 1'b0;
          end
          KIND_RECORD: begin
            if (r.gap != '0) begin
              if (!hist_live[ix]) begin
                hist_live[ix] = 1'b1;
                hist[ix]      = '{last_acc: now, last_ref: now, cnt: '0};
              end else begin
                if (since_acc > r.gap) hist[ix].last_acc = now;
                else if (hist[ix].cnt != CNT_MAX) hist[ix].cnt = hist[ix].cnt + CNT_W'(1);
                // refresh window elapsed: history starts over
                if (since_ref > r.refresh) hist[ix] = '{last_acc: now, last_ref: now, cnt: '0};
              end
            end
          end
          default: ;
        endcase
      end else if (kind == KIND_CHECK) begin
        v.accepted = 1'b0;
      end
      verdict_q.push_back(v);
    endfunction

    function void match_verdict(logic acc, logic known);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        $display("%0t: result with nothing expected, accepted=%b known_type=%b",
                 $time, acc, known);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      if (acc !== want.accepted) begin
        $display("%0t: accepted mismatch, expected %b, actual %b", $time, want.accepted, acc);
        errors++;
      end
      if (known !== want.known) begin
        $display("%0t: known_type mismatch, expected %b, actual %b", $time, want.known, known);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        kind_i;
  logic [TYPE_W-1:0] message_type_i;
  logic [TIME_W-1:0] arrival_time_i;
  logic [TIME_W-1:0] rule_min_gap_i;
  logic [TIME_W-1:0] rule_refresh_period_i;
  logic [CNT_W-1:0]  rule_allowed_errors_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              accepted_o;
  logic              known_type_o;

  policy_tracker tracker;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   quiet_cycles   = 0;

  per_type_message_rate_policer u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .kind_i                (kind_i),
    .message_type_i        (message_type_i),
    .arrival_time_i        (arrival_time_i),
    .rule_min_gap_i        (rule_min_gap_i),
    .rule_refresh_period_i (rule_refresh_period_i),
    .rule_allowed_errors_i (rule_allowed_errors_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .accepted_o            (accepted_o),
    .known_type_o          (known_type_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.match_verdict(accepted_o, known_type_o);
  end

  // ends a hung run: counts cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[per_type_message_rate_policer] ERROR");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] kind, input logic [TYPE_W-1:0] mtype,
                           input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] gap,
                           input logic [TIME_W-1:0] refresh, input logic [CNT_W-1:0] allowed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    kind_i                = kind;
    message_type_i        = mtype;
    arrival_time_i        = now;
    rule_min_gap_i        = gap;
    rule_refresh_period_i = refresh;
    rule_allowed_errors_i = allowed;
    in_valid_i            = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_message(kind, mtype, now, gap, refresh, allowed);
    @(negedge clk_i);
  endtask

  // small set of types so histories build up over many items
  function automatic logic [TYPE_W-1:0] pool_type();
    case ($urandom_range(5))
      0:       return TYPE_W'(0);
      1:       return TYPE_W'(1);
      2:       return TYPE_W'(42);
      3:       return TYPE_W'(128);
      4:       return TYPE_W'(254);
      default: return TYPE_W'(255);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_gap();
    case ($urandom_range(7))
      0:       return '0;
      1:       return TIME_W'(1);
      2, 3:    return TIME_W'(100);
      4:       return TIME_W'(500);
      5:       return TIME_W'(1000);
      6:       return TIME_W'(5000);
      default: return TIME_W'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_refresh();
    case ($urandom_range(5))
      0:       return TIME_W'(2000);
      1:       return TIME_W'(5000);
      2:       return TIME_W'(1000);
      3:       return '0;
      4:       return TIME_W'(500);
      default: return TIME_W'($urandom_range(100, 3000));
    endcase
  endfunction

  initial begin
    logic [TIME_W-1:0] clock_ms;
    int unsigned       roll;
    tracker               = new();
    rst_ni                = 1'b0;
    in_valid_i            = 1'b0;
    kind_i                = KIND_LOAD;
    message_type_i        = '0;
    arrival_time_i        = '0;
    rule_min_gap_i        = '0;
    rule_refresh_period_i = '0;
    rule_allowed_errors_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset rules: unpoliced, so nothing is tracked
    push_item(KIND_CHECK, 16'd0, 32'd0, '0, '0, '0);
    push_item(KIND_RECORD, 16'd0, 32'd10, '0, '0, '0);
    // unknown types and the spare kind
    push_item(KIND_CHECK, 16'hFFFF, 32'hFFFF_FFFF, '1, '1, '1);
    push_item(KIND_LOAD, 16'd256, '0, '1, '1, '1);
    push_item(KIND_RECORD, 16'h8000, 32'd20, '0, '0, '0);
    push_item(KIND_SPARE, 16'd5, 32'd30, '1, '1, '1);
    push_item(KIND_SPARE, 16'hFFFF, 32'd30, '0, '0, '0);
    // early arrivals past the allowed count get rejected
    push_item(KIND_LOAD, 16'd0, '0, 32'd100, 32'd5000, 16'd1);
    push_item(KIND_CHECK, 16'd0, 32'd900, '0, '0, '0);
    push_item(KIND_RECORD, 16'd0, 32'd1000, '0, '0, '0);
    push_item(KIND_CHECK, 16'd0, 32'd1050, '0, '0, '0);
    push_item(KIND_RECORD, 16'd0, 32'd1050, '0, '0, '0);
    push_item(KIND_RECORD, 16'd0, 32'd1100, '0, '0, '0);
    push_item(KIND_CHECK, 16'd0, 32'd1099, '0, '0, '0);
    push_item(KIND_CHECK, 16'd0, 32'd1100, '0, '0, '0);
    push_item(KIND_RECORD, 16'd0, 32'd1101, '0, '0, '0);
    push_item(KIND_CHECK, 16'd0, 32'd1150, '0, '0, '0);
    // reload keeps the history, only the allowed count moves
    push_item(KIND_LOAD, 16'd0, '0, 32'd100, 32'd5000, 16'd2);
    push_item(KIND_CHECK, 16'd0, 32'd1150, '0, '0, '0);
    push_item(KIND_RECORD, 16'd0, 32'd7000, '0, '0, '0);
    push_item(KIND_CHECK, 16'd0, 32'd7001, '0, '0, '0);
    // time difference across the 32-bit wrap
    push_item(KIND_LOAD, 16'd255, '0, '1, '1, 16'd0);
    push_item(KIND_RECORD, 16'd255, 32'hFFFF_FFF0, '0, '0, '0);
    push_item(KIND_RECORD, 16'd255, 32'h0000_0010, '0, '0, '0);
    push_item(KIND_CHECK, 16'd255, 32'h0000_0020, '0, '0, '0);

    // burst of early records drives the violation count well past the allowed count
    push_item(KIND_LOAD, BURST_TYPE, '0, '1, '1, CNT_W'(3));
    for (int n = 0; n < BURST_LEN; n++)
      push_item(KIND_RECORD, BURST_TYPE, 32'h1234_5678, $urandom, $urandom,
                CNT_W'($urandom));
    push_item(KIND_CHECK, BURST_TYPE, 32'h1234_5678, '0, '0, '0);
    push_item(KIND_LOAD, BURST_TYPE, '0, '1, '1, CNT_MAX);
    push_item(KIND_CHECK, BURST_TYPE, 32'h1234_5679, '0, '0, '0);

    clock_ms = $urandom;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if ($urandom_range(49) == 0) clock_ms += $urandom_range(1000, 8000);
        else clock_ms += $urandom_range(0, 150);
        if (roll < 8)
          push_item(KIND_LOAD, pool_type(), $urandom, pick_gap(), pick_refresh(),
                    CNT_W'($urandom_range(0, 3)));
        else if (roll < 10)
          push_item(KIND_LOAD, TYPE_W'($urandom_range(0, NUM_TYPES - 1)), $urandom, $urandom,
                    $urandom, CNT_W'($urandom));
        else if (roll < 50)
          push_item(KIND_RECORD, pool_type(), clock_ms, $urandom, $urandom, CNT_W'($urandom));
        else if (roll < 85)
          push_item(KIND_CHECK, pool_type(), clock_ms, $urandom, $urandom, CNT_W'($urandom));
        else if (roll < 90)
          push_item(KIND_SPARE, TYPE_W'($urandom), $urandom, $urandom, $urandom,
                    CNT_W'($urandom));
        else if (roll < 95)
          push_item(2'($urandom_range(0, 2)), TYPE_W'($urandom_range(NUM_TYPES, 65535)),
                    $urandom, $urandom, $urandom, CNT_W'($urandom));
        else
          push_item(2'($urandom_range(0, 2)), TYPE_W'($urandom_range(0, NUM_TYPES - 1)),
                    $urandom, $urandom, $urandom, CNT_W'($urandom));
      end
    end

    in_valid_i = 1'b0;
    while (tracker.verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) $display("[per_type_message_rate_policer] OK");
    else $display("[per_type_message_rate_policer] ERROR");
    $finish;
  end

endmodule
